### design/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int REP_MAX         = 8;
    localparam int MAX_RESULTS     = REP_MAX + 1;
    localparam int QUEUE_DEPTH     = 2 * MAX_RESULTS;
    localparam int MAX_PATTERN_DEF = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIND_PATTERN   = 2'd0,
        REG_FIND_LENGTH    = 2'd1,
        REG_REPLACE_TEXT   = 2'd2,
        REG_REPLACE_LENGTH = 2'd3
    } sfr_reg_idx_t;

    // Result bytes caused by one request, first byte in entry 0
    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
        logic [LEN_W-1:0]                   count;
    } sfr_list_t;

    // Per-cell control of the output chain
    typedef struct packed {
        logic shift;
        logic load;
    } sfr_cell_ctl_t;

endpackage

`default_nettype wire

### design/sfr_match.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_match
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire logic                          clear,
    input  wire logic [BYTE_W-1:0]             in_byte,
    input  wire logic                          eof,
    input  wire logic [MAX_PATTERN*BYTE_W-1:0] pattern,
    input  wire logic [LEN_W-1:0]              plen,
    input  wire logic [REP_MAX*BYTE_W-1:0]     replace,
    input  wire logic [LEN_W-1:0]              rlen,
    output sfr_list_t                          list
);

    localparam int KW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [KW-1:0]     matched_count_reg;
    logic [KW-1:0]     matched_count_next;
    logic [LEN_W-1:0]  kx;
    logic [BYTE_W-1:0] pat_b  [MAX_PATTERN];
    logic [BYTE_W-1:0] held_b [MAX_PATTERN];
    logic              cand   [MAX_PATTERN];
    logic [LEN_W-1:0]  jsel;
    logic              hit;
    logic              src_rep;
    logic              xe;
    logic              ne;
    logic [LEN_W-1:0]  seg_a;
    logic [LEN_W-1:0]  seg_f;
    logic [LEN_W-1:0]  kn;
    logic [LEN_W-1:0]  k_after;

    function automatic logic [BYTE_W-1:0] pick_p(
        input logic [MAX_PATTERN*BYTE_W-1:0] word,
        input logic [LEN_W-1:0]              idx
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int m = 0; m < MAX_PATTERN; m++) begin
            if (idx == LEN_W'(m)) begin
                b = word[m*BYTE_W +: BYTE_W];
            end
        end
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_r(input logic [LEN_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int m = 0; m < REP_MAX; m++) begin
            if (idx == LEN_W'(m)) begin
                b = replace[m*BYTE_W +: BYTE_W];
            end
        end
        return b;
    endfunction

    assign kx  = LEN_W'(matched_count_reg);
    assign hit = (pick_p(pattern, kx) == in_byte);

    // Pattern bytes, and the held bytes read backwards from the newest
    for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_bytes
        assign pat_b[m]  = pattern[m*BYTE_W +: BYTE_W];
        assign held_b[m] = pick_p(pattern, kx - LEN_W'(1) - LEN_W'(m));
    end

    // Test every fallback length: held suffix plus new byte against pattern prefix
    always_comb begin
        cand[0] = 1'b0;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            cand[j] = (LEN_W'(j) <= kx) && (in_byte == pat_b[j-1]);
            for (int i = 0; i < j - 1; i++) begin
                if (held_b[j-2-i] != pat_b[i]) begin
                    cand[j] = 1'b0;
                end
            end
        end
    end

    // Keep the longest fallback
    always_comb begin
        jsel = '0;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            if (cand[j]) begin
                jsel = LEN_W'(j);
            end
        end
    end

    // Describe the result as: source prefix, optional byte, held flush, newline
    always_comb begin
        src_rep = 1'b0;
        seg_a   = '0;
        xe      = 1'b0;
        kn      = '0;
        if (plen == '0) begin
            xe = 1'b1;
        end else if (in_byte == NEWLINE) begin
            seg_a = kx;
            xe    = 1'b1;
        end else if (hit) begin
            if (kx + LEN_W'(1) == plen) begin
                src_rep = 1'b1;
                seg_a   = rlen;
            end else begin
                kn = kx + LEN_W'(1);
            end
        end else begin
            kn = jsel;
            if (jsel == '0) begin
                seg_a = kx;
                xe    = 1'b1;
            end else begin
                seg_a = kx + LEN_W'(1) - jsel;
            end
        end
        if (eof) begin
            seg_f   = kn;
            ne      = (in_byte != NEWLINE);
            k_after = '0;
        end else begin
            seg_f   = '0;
            ne      = 1'b0;
            k_after = kn;
        end
    end

    assign list.count = seg_a + LEN_W'(xe) + seg_f + LEN_W'(ne);

    // Place each result byte
    for (genvar p = 0; p < MAX_RESULTS; p++) begin : g_pos
        logic [LEN_W-1:0]  q;
        logic [LEN_W-1:0]  r;
        logic [BYTE_W-1:0] pb;
        assign q = LEN_W'(p) - seg_a;
        assign r = q - LEN_W'(xe);
        always_comb begin
            if (LEN_W'(p) < seg_a) begin
                pb = src_rep ? pick_r(LEN_W'(p)) : pick_p(pattern, LEN_W'(p));
            end else if (xe && q == '0) begin
                pb = in_byte;
            end else if (r < seg_f) begin
                pb = pick_p(pattern, r);
            end else begin
                pb = NEWLINE;
            end
        end
        assign list.data[p] = pb;
    end

    // Advance the partial match length
    always_comb begin
        matched_count_next = matched_count_reg;
        if (clear) begin
            matched_count_next = '0;
        end else if (fire) begin
            matched_count_next = KW'(k_after);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matched_count_reg <= '0;
        end else begin
            matched_count_reg <= matched_count_next;
        end
    end

`ifndef SYNTH
    a_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        plen != '0 |-> LEN_W'(matched_count_reg) < plen)
        else $error("partial match not shorter than pattern");
    a_newline_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_byte == NEWLINE |=> matched_count_reg == '0)
        else $error("newline left a partial match");
    a_list_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> list.count <= LEN_W'(MAX_RESULTS))
        else $error("result list longer than allowed");
`endif

endmodule

`default_nettype wire

### design/sfr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_cell
    import sfr_pkg::*;
(
    input  wire logic              aclk,
    input  wire sfr_cell_ctl_t     ctl,
    input  wire logic [BYTE_W-1:0] load_byte,
    input  wire logic              load_last,
    input  wire logic [BYTE_W-1:0] nb_byte,
    input  wire logic              nb_last,
    output logic      [BYTE_W-1:0] cell_byte,
    output logic                   cell_last
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              last_reg;
    logic              last_next;

    // Load a new result, else take the neighbour's on a shift, else hold
    always_comb begin
        byte_next = byte_reg;
        last_next = last_reg;
        if (ctl.load) begin
            byte_next = load_byte;
            last_next = load_last;
        end else if (ctl.shift) begin
            byte_next = nb_byte;
            last_next = nb_last;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign cell_byte = byte_reg;
    assign cell_last = last_reg;

endmodule

`default_nettype wire

### design/sfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sfr_list_t         list,
    output logic                   room,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [BYTE_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     base;
    logic [CW-1:0]     n_ext;
    logic              pop;
    logic [BYTE_W-1:0] chain_byte [DEPTH+1];
    logic              chain_last [DEPTH+1];

    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign room     = (cnt_reg <= CW'(DEPTH - MAX_RESULTS));
    assign base     = cnt_reg - CW'(pop);
    assign n_ext    = CW'(list.count);
    assign cnt_next = base + (push ? n_ext : '0);

    // Beyond the last cell nothing moves in
    assign chain_byte[DEPTH] = '0;
    assign chain_last[DEPTH] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [CW-1:0]     off;
        logic [BYTE_W-1:0] ld_byte;
        sfr_cell_ctl_t     ctl;

        assign off       = CW'(i) - base;
        assign ctl.shift = pop;
        assign ctl.load  = push && (CW'(i) >= base) && (off < n_ext);

        // Select this cell's byte from the new result list
        always_comb begin
            ld_byte = '0;
            for (int m = 0; m < MAX_RESULTS; m++) begin
                if (off == CW'(m)) begin
                    ld_byte = list.data[m];
                end
            end
        end

        sfr_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .load_byte (ld_byte),
            .load_last (off == n_ext - CW'(1)),
            .nb_byte   (chain_byte[i+1]),
            .nb_last   (chain_last[i+1]),
            .cell_byte (chain_byte[i]),
            .cell_last (chain_last[i])
        );
    end

    assign m_tdata = chain_byte[0];
    assign m_tlast = chain_last[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("output chain overfilled");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + $past(n_ext))
        else $error("fill count lost a pushed request");
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("fill count wrong after a pop");
`endif

endmodule

`default_nettype wire

### design/stream_search_and_replace.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming search and replace. Text arrives one byte per request on the
// s_ side; every leftmost, non-overlapping occurrence of the pattern (up to
// MAX_PATTERN bytes) is replaced by the replacement text (up to 8 bytes),
// and replaced text is not searched again. A newline ends any partial match;
// the request flagged with s_tlast flushes held bytes and appends a newline
// unless it was one. Each request yields 0 to 9 result bytes on the m_ side,
// the last of them flagged by m_tlast. The match is resolved in the cycle a
// request is accepted and its bytes enter an 18-cell output chain at that
// same edge, so the first result can be taken in the cycle after acceptance.
// Requests are taken one per cycle while the chain holds at most 9 bytes;
// the chain drains one byte per cycle while m_tready is high, so sustained
// throughput is one request per cycle if requests average at most one byte.
// Program the registers only while the block is idle; writing the pattern
// or its length drops any partial match.
module stream_search_and_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    input  wire logic                  s_tlast,   // end_of_file
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                       m_tlast    // last_of_run
);

    localparam int PW = MAX_PATTERN * BYTE_W;
    localparam int RW = REP_MAX * BYTE_W;

    logic [PW-1:0]    find_pattern_reg;
    logic [PW-1:0]    find_pattern_next;
    logic [LEN_W-1:0] find_length_reg;
    logic [LEN_W-1:0] find_length_next;
    logic [RW-1:0]    replace_text_reg;
    logic [RW-1:0]    replace_text_next;
    logic [LEN_W-1:0] replace_length_reg;
    logic [LEN_W-1:0] replace_length_next;
    logic             cfg_fire;
    logic             pat_clear;
    logic             s_fire;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    sfr_list_t        list;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_tvalid && s_tready;

    // Decode register writes
    always_comb begin
        find_pattern_next   = find_pattern_reg;
        find_length_next    = find_length_reg;
        replace_text_next   = replace_text_reg;
        replace_length_next = replace_length_reg;
        pat_clear           = 1'b0;
        if (cfg_fire) begin
            unique case (sfr_reg_idx_t'(cfg_index))
                REG_FIND_PATTERN: begin
                    find_pattern_next = cfg_data[PW-1:0];
                    pat_clear         = 1'b1;
                end
                REG_FIND_LENGTH: begin
                    find_length_next = cfg_data[LEN_W-1:0];
                    pat_clear        = 1'b1;
                end
                REG_REPLACE_TEXT: begin
                    replace_text_next = cfg_data[RW-1:0];
                end
                REG_REPLACE_LENGTH: begin
                    replace_length_next = cfg_data[LEN_W-1:0];
                end
                default: begin
                    pat_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_pattern_reg   <= '0;
            find_length_reg    <= '0;
            replace_text_reg   <= '0;
            replace_length_reg <= '0;
        end else begin
            find_pattern_reg   <= find_pattern_next;
            find_length_reg    <= find_length_next;
            replace_text_reg   <= replace_text_next;
            replace_length_reg <= replace_length_next;
        end
    end

    // Clamp lengths to the storage in use
    assign plen = (find_length_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : find_length_reg;
    assign rlen = (replace_length_reg > LEN_W'(REP_MAX)) ? LEN_W'(REP_MAX)
                                                         : replace_length_reg;

    sfr_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (s_fire),
        .clear   (pat_clear),
        .in_byte (s_tdata),
        .eof     (s_tlast),
        .pattern (find_pattern_reg),
        .plen    (plen),
        .replace (replace_text_reg),
        .rlen    (rlen),
        .list    (list)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_fire),
        .list     (list),
        .room     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
